// ===== rtl/pcb_pkg.sv =====
// Shared types and constants for the path convex corridor bounds block.
// Operation, status and register codes, position type and the scan step struct.
// No dependencies.
`default_nettype none

package pcb_pkg;

  // Signed Q15.8 position, metres
  typedef logic signed [23:0] pos_t;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_OBSTACLE = 2'd1,
    OP_READ     = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BEYOND = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_ROAD_UPPER  = 2'd0,
    CFG_ROAD_LOWER  = 2'd1,
    CFG_HALF_LENGTH = 2'd2,
    CFG_HALF_WIDTH  = 2'd3
  } cfg_e;

  localparam pos_t        ROAD_UPPER_RST  = 24'sd1024;
  localparam pos_t        ROAD_LOWER_RST  = -24'sd1024;
  localparam logic [15:0] HALF_LENGTH_RST = 16'd640;
  localparam logic [15:0] HALF_WIDTH_RST  = 16'd384;

  // One station sample delivered by the path scan
  typedef struct packed {
    logic valid;
    logic first;
    pos_t prev;
    pos_t cur;
  } scan_step_t;

endpackage

`default_nettype wire

// ===== rtl/path_convex_corridor_bounds.sv =====
// Path convex corridor bounds: top level with sequencer, point and bound memories.
// Uses pcb_pkg, pcb_ram and pcb_near.
//
// Usage:
//   Configuration: write road bounds and obstacle half sizes through cfg_we_i,
//   cfg_index_i and cfg_data_i while the block is idle; a write takes effect at
//   the clock edge it is presented on.
//   Input channel (in_valid_i / in_stall_o): one transfer carries an operation,
//   an index, a station and a lateral offset. Output channel (out_valid_o /
//   out_stall_i): every input transfer yields exactly one result transfer.
//   Sequencing: a point write, a bound read, an unused code or an obstacle on an
//   empty path goes straight to the completion state and loads the output
//   register from there; the next item is accepted once that result is loaded.
//   An obstacle scans the station memory one point per cycle, reads the center
//   lateral, compares, then read-modify-writes the bounds over the span, one
//   point per cycle, and then completes; a dropped obstacle skips compare and
//   span walk. The single read port of each memory sets this pace.
//   Stall: the result sits in an output register; the next item is accepted
//   while it waits, and a finished item holds until the register frees.
//   Reset: clears control state, the point count and the configuration to its
//   defaults; memory contents are not cleared and entries read as written.
`default_nettype none

module path_convex_corridor_bounds #(
  parameter int MAX_POINTS = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         operation_i,
  input  wire logic [7:0]         point_index_i,
  input  wire logic signed [23:0] station_i,
  input  wire logic signed [23:0] lateral_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [23:0]      lower_bound_o,
  output logic signed [23:0]      upper_bound_o,
  output logic [1:0]              status_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAT,
    S_CMP,
    S_SPAN,
    S_DONE
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  pcb_pkg::pos_t road_hi_q;
  pcb_pkg::pos_t road_lo_q;
  logic [15:0]   half_len_q;
  logic [15:0]   half_wid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      road_hi_q  <= pcb_pkg::ROAD_UPPER_RST;
      road_lo_q  <= pcb_pkg::ROAD_LOWER_RST;
      half_len_q <= pcb_pkg::HALF_LENGTH_RST;
      half_wid_q <= pcb_pkg::HALF_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (pcb_pkg::cfg_e'(cfg_index_i))
        pcb_pkg::CFG_ROAD_UPPER:  road_hi_q  <= cfg_data_i;
        pcb_pkg::CFG_ROAD_LOWER:  road_lo_q  <= cfg_data_i;
        pcb_pkg::CFG_HALF_LENGTH: half_len_q <= cfg_data_i[15:0];
        pcb_pkg::CFG_HALF_WIDTH:  half_wid_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Clamp a 25-bit sum to the signed 24-bit range
  function automatic pcb_pkg::pos_t sat24(input logic signed [24:0] v);
    logic [23:0] r;
    if (v[24] != v[23]) begin
      r = v[24] ? {1'b1, 23'd0} : {1'b0, {23{1'b1}}};
    end else begin
      r = v[23:0];
    end
    return pcb_pkg::pos_t'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Memories: point memory holds {station, lateral}, bound memory {low, high}
  // ---------------------------------------------------------------------------
  logic             pt_we;
  logic [IDX_W-1:0] pt_waddr;
  logic [47:0]      pt_wdata;
  logic             pt_re;
  logic [IDX_W-1:0] pt_raddr;
  logic [47:0]      pt_rdata;

  logic             bd_we;
  logic [IDX_W-1:0] bd_waddr;
  logic [47:0]      bd_wdata;
  logic             bd_re;
  logic [IDX_W-1:0] bd_raddr;
  logic [47:0]      bd_rdata;

  pcb_ram #(
    .DEPTH (MAX_POINTS),
    .WIDTH (48)
  ) u_point_mem (
    .clk_i   (clk_i),
    .we_i    (pt_we),
    .waddr_i (pt_waddr),
    .wdata_i (pt_wdata),
    .re_i    (pt_re),
    .raddr_i (pt_raddr),
    .rdata_o (pt_rdata)
  );

  pcb_ram #(
    .DEPTH (MAX_POINTS),
    .WIDTH (48)
  ) u_bound_mem (
    .clk_i   (clk_i),
    .we_i    (bd_we),
    .waddr_i (bd_waddr),
    .wdata_i (bd_wdata),
    .re_i    (bd_re),
    .raddr_i (bd_raddr),
    .rdata_o (bd_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_q, rd_d;          // next address to read
  logic [CNT_W-1:0]  end_q, end_d;        // last address of the walk
  logic              dv_q, dv_d;          // read data valid this cycle
  logic [IDX_W-1:0]  dv_idx_q, dv_idx_d;  // address of that read data
  pcb_pkg::pos_t     prev_q, prev_d;      // previous station in the scan
  pcb_pkg::pos_t     lat_q, lat_d;        // obstacle lateral
  logic              side_q, side_d;      // path passes left of the obstacle
  pcb_pkg::pos_t     lim_q, lim_d;
  pcb_pkg::status_e  res_status_q, res_status_d;
  logic              res_mem_q, res_mem_d;
  logic              out_valid_q, out_valid_d;
  pcb_pkg::pos_t     out_lo_q, out_lo_d;
  pcb_pkg::pos_t     out_hi_q, out_hi_d;
  pcb_pkg::status_e  out_status_q, out_status_d;

  // ---------------------------------------------------------------------------
  // Nearest-point trackers: center, span start, span end
  // ---------------------------------------------------------------------------
  logic                near_clear;
  pcb_pkg::scan_step_t step;
  logic signed [24:0]  st_ext;
  logic signed [24:0]  hl_ext;
  logic signed [24:0]  tgt_c, tgt_a, tgt_b;
  logic                ok_c, ok_a, ok_b;
  logic [IDX_W-1:0]    idx_c, idx_a, idx_b;
  logic                one_point;

  assign st_ext    = {station_i[23], station_i};
  assign hl_ext    = {9'd0, half_len_q};
  assign tgt_c     = st_ext;
  assign tgt_a     = st_ext - hl_ext;
  assign tgt_b     = st_ext + hl_ext;
  assign one_point = (count_q == CNT_W'(1));

  assign step.valid = (state_q == S_SCAN) && dv_q;
  assign step.first = (dv_idx_q == '0);
  assign step.prev  = prev_q;
  assign step.cur   = pt_rdata[47:24];

  pcb_near #(.IDX_W(IDX_W)) u_near_c (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (near_clear),
    .target_i    (tgt_c),
    .step_i      (step),
    .step_idx_i  (dv_idx_q),
    .last_idx_i  (end_q[IDX_W-1:0]),
    .one_point_i (one_point),
    .ok_o        (ok_c),
    .index_o     (idx_c)
  );

  pcb_near #(.IDX_W(IDX_W)) u_near_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (near_clear),
    .target_i    (tgt_a),
    .step_i      (step),
    .step_idx_i  (dv_idx_q),
    .last_idx_i  (end_q[IDX_W-1:0]),
    .one_point_i (one_point),
    .ok_o        (ok_a),
    .index_o     (idx_a)
  );

  pcb_near #(.IDX_W(IDX_W)) u_near_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (near_clear),
    .target_i    (tgt_b),
    .step_i      (step),
    .step_idx_i  (dv_idx_q),
    .last_idx_i  (end_q[IDX_W-1:0]),
    .one_point_i (one_point),
    .ok_o        (ok_b),
    .index_o     (idx_b)
  );

  // ---------------------------------------------------------------------------
  // Next-state and memory control
  // ---------------------------------------------------------------------------
  logic             accept;
  logic             out_free;
  logic             idx_fits;
  logic [IDX_W-1:0] idx_addr;
  pcb_pkg::pos_t    lat_c;
  pcb_pkg::pos_t    cur_lo;
  pcb_pkg::pos_t    cur_hi;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign idx_fits   = 32'(point_index_i) < 32'(MAX_POINTS);
  assign idx_addr   = IDX_W'(point_index_i);
  assign lat_c      = pt_rdata[23:0];
  assign cur_lo     = bd_rdata[47:24];
  assign cur_hi     = bd_rdata[23:0];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_d         = rd_q;
    end_d        = end_q;
    dv_d         = 1'b0;
    dv_idx_d     = dv_idx_q;
    prev_d       = prev_q;
    lat_d        = lat_q;
    side_d       = side_q;
    lim_d        = lim_q;
    res_status_d = res_status_q;
    res_mem_d    = res_mem_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_lo_d     = out_lo_q;
    out_hi_d     = out_hi_q;
    out_status_d = out_status_q;

    near_clear = 1'b0;
    pt_we      = 1'b0;
    pt_waddr   = idx_addr;
    pt_wdata   = {station_i, lateral_i};
    pt_re      = 1'b0;
    pt_raddr   = rd_q[IDX_W-1:0];
    bd_we      = 1'b0;
    bd_waddr   = idx_addr;
    bd_wdata   = {road_lo_q, road_hi_q};
    bd_re      = 1'b0;
    bd_raddr   = rd_q[IDX_W-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = pcb_pkg::ST_OK;
          res_mem_d    = 1'b0;
          state_d      = S_DONE;
          case (pcb_pkg::op_e'(operation_i))
            pcb_pkg::OP_WRITE: begin
              if (idx_fits) begin
                // store the point and reset its bounds to the road
                pt_we   = 1'b1;
                bd_we   = 1'b1;
                count_d = CNT_W'(point_index_i) + CNT_W'(1);
              end else begin
                res_status_d = pcb_pkg::ST_BEYOND;
              end
            end
            pcb_pkg::OP_OBSTACLE: begin
              if (count_q == '0) begin
                res_status_d = pcb_pkg::ST_EMPTY;
              end else begin
                // start the station scan at point 0
                near_clear = 1'b1;
                pt_re      = 1'b1;
                pt_raddr   = '0;
                rd_d       = CNT_W'(1);
                end_d      = count_q - CNT_W'(1);
                dv_d       = 1'b1;
                dv_idx_d   = '0;
                lat_d      = lateral_i;
                state_d    = S_SCAN;
              end
            end
            pcb_pkg::OP_READ: begin
              if (count_q == '0) begin
                res_status_d = pcb_pkg::ST_EMPTY;
              end else if (32'(point_index_i) >= 32'(count_q)) begin
                res_status_d = pcb_pkg::ST_BEYOND;
              end else begin
                bd_re     = 1'b1;
                bd_raddr  = idx_addr;
                res_mem_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        if (dv_q) begin
          prev_d = pt_rdata[47:24];
        end
        if (rd_q <= end_q) begin
          pt_re    = 1'b1;
          dv_d     = 1'b1;
          dv_idx_d = rd_q[IDX_W-1:0];
          rd_d     = rd_q + CNT_W'(1);
        end
        if (dv_q && (dv_idx_q == end_q[IDX_W-1:0])) begin
          state_d = S_LAT;
        end
      end

      S_LAT: begin
        res_status_d = pcb_pkg::ST_OK;
        // drop the obstacle if a search failed or the span is reversed
        if (!(ok_c && ok_a && ok_b) || (idx_a > idx_b)) begin
          state_d = S_DONE;
        end else begin
          pt_re    = 1'b1;
          pt_raddr = idx_c;
          rd_d     = CNT_W'(idx_a);
          end_d    = CNT_W'(idx_b);
          state_d  = S_CMP;
        end
      end

      S_CMP: begin
        side_d = lat_c > lat_q;
        lim_d  = (lat_c > lat_q)
               ? sat24({lat_q[23], lat_q} + {9'd0, half_wid_q})
               : sat24({lat_q[23], lat_q} - {9'd0, half_wid_q});
        // first bound read of the span
        bd_re    = 1'b1;
        dv_d     = 1'b1;
        dv_idx_d = rd_q[IDX_W-1:0];
        rd_d     = rd_q + CNT_W'(1);
        state_d  = S_SPAN;
      end

      S_SPAN: begin
        // write back entry j while reading entry j+1
        if (dv_q) begin
          bd_we    = 1'b1;
          bd_waddr = dv_idx_q;
          if (side_q) begin
            bd_wdata = {((cur_lo < lim_q) ? lim_q : cur_lo), cur_hi};
          end else begin
            bd_wdata = {cur_lo, ((cur_hi > lim_q) ? lim_q : cur_hi)};
          end
        end
        if (rd_q <= end_q) begin
          bd_re    = 1'b1;
          dv_d     = 1'b1;
          dv_idx_d = rd_q[IDX_W-1:0];
          rd_d     = rd_q + CNT_W'(1);
        end
        if (dv_q && (dv_idx_q == end_q[IDX_W-1:0])) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register frees
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_lo_d     = res_mem_q ? cur_lo : '0;
          out_hi_d     = res_mem_q ? cur_hi : '0;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      rd_q         <= '0;
      end_q        <= '0;
      dv_q         <= 1'b0;
      dv_idx_q     <= '0;
      prev_q       <= '0;
      lat_q        <= '0;
      side_q       <= 1'b0;
      lim_q        <= '0;
      res_status_q <= pcb_pkg::ST_OK;
      res_mem_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_lo_q     <= '0;
      out_hi_q     <= '0;
      out_status_q <= pcb_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      rd_q         <= rd_d;
      end_q        <= end_d;
      dv_q         <= dv_d;
      dv_idx_q     <= dv_idx_d;
      prev_q       <= prev_d;
      lat_q        <= lat_d;
      side_q       <= side_d;
      lim_q        <= lim_d;
      res_status_q <= res_status_d;
      res_mem_q    <= res_mem_d;
      out_valid_q  <= out_valid_d;
      out_lo_q     <= out_lo_d;
      out_hi_q     <= out_hi_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lower_bound_o = out_lo_q;
  assign upper_bound_o = out_hi_q;
  assign status_o      = out_status_q;

`ifndef SYNTHESIS
  // The span walk never touches an entry past the span end
  a_span_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPAN && dv_q) |-> (CNT_W'(dv_idx_q) <= end_q))
    else $error("bound walk past span end");

  // The loaded point count never exceeds the memory depth
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAX_POINTS))
    else $error("point count beyond depth");

  // A new result only comes from the completion state
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside completion");
`endif

endmodule

`default_nettype wire

// ===== rtl/pcb_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port.
// Read data is registered and holds between reads.
// No dependencies.
`default_nettype none

module pcb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/pcb_near.sv =====
// Nearest-point tracker for one query station, fed by the sequential path scan.
// Uses pcb_pkg (pos_t, scan_step_t).
`default_nettype none

module pcb_near #(
  parameter int IDX_W = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clear_i,
  input  wire logic signed [24:0]      target_i,
  input  wire pcb_pkg::scan_step_t     step_i,
  input  wire logic [IDX_W-1:0]        step_idx_i,
  input  wire logic [IDX_W-1:0]        last_idx_i,
  input  wire logic                    one_point_i,
  output logic                         ok_o,
  output logic [IDX_W-1:0]             index_o
);

  logic signed [24:0] target_q;
  logic               below_q;
  logic               above_q;
  logic               hit_q;
  logic [IDX_W-1:0]   pick_q;

  logic signed [24:0] prev_ext;
  logic signed [24:0] cur_ext;
  logic signed [25:0] d_lo;
  logic signed [25:0] d_hi;
  logic               in_pair;

  assign prev_ext = {step_i.prev[23], step_i.prev};
  assign cur_ext  = {step_i.cur[23], step_i.cur};
  assign d_lo     = {target_q[24], target_q} - {prev_ext[24], prev_ext};
  assign d_hi     = {cur_ext[24], cur_ext} - {target_q[24], target_q};
  assign in_pair  = (target_q >= prev_ext) && (target_q <= cur_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      below_q  <= 1'b0;
      above_q  <= 1'b0;
      hit_q    <= 1'b0;
      pick_q   <= '0;
    end else if (clear_i) begin
      target_q <= target_i;
      below_q  <= 1'b0;
      above_q  <= 1'b0;
      hit_q    <= 1'b0;
    end else if (step_i.valid) begin
      if (step_i.first) begin
        below_q <= target_q < cur_ext;
      end
      // last step leaves the compare against the final point
      above_q <= target_q > cur_ext;
      // first matching pair wins; tie goes to the lower point
      if (!step_i.first && !hit_q && in_pair) begin
        hit_q  <= 1'b1;
        pick_q <= (d_lo <= d_hi) ? (step_idx_i - IDX_W'(1)) : step_idx_i;
      end
    end
  end

  assign ok_o    = one_point_i || below_q || above_q || hit_q;
  assign index_o = (one_point_i || below_q) ? '0 : (above_q ? last_idx_i : pick_q);

endmodule

`default_nettype wire
